FILE: design/ghist_pkg.sv
`default_nettype none
package ghist_pkg;

	localparam int MAX_ROWS   = 64;
	localparam int MAX_COLS   = 64;
	localparam int COUNT_BITS = 16;

	localparam int ROW_BITS  = $clog2(MAX_ROWS);
	localparam int COL_BITS  = $clog2(MAX_COLS);
	localparam int ADDR_BITS = ROW_BITS + COL_BITS;
	localparam int DIM_BITS  = 7;
	localparam int SHARE_BITS = 17;
	localparam int STAT_BITS  = 3;

	typedef logic [COUNT_BITS-1:0] count_t;
	typedef logic [ADDR_BITS-1:0]  addr_t;
	typedef logic [DIM_BITS-1:0]   dim_t;
	typedef logic [SHARE_BITS-1:0] share_t;
	typedef logic [STAT_BITS-1:0]  stat_t;

	localparam count_t COUNT_MAX = '1;
	localparam dim_t   ROWS_LIMIT = dim_t'(MAX_ROWS);
	localparam dim_t   COLS_LIMIT = dim_t'(MAX_COLS);

	localparam logic [1:0] REQ_ADD   = 2'd0;
	localparam logic [1:0] REQ_REM   = 2'd1;
	localparam logic [1:0] REQ_QUERY = 2'd2;
	localparam logic [1:0] REQ_CLEAR = 2'd3;

	localparam stat_t STAT_OK      = 3'd0;
	localparam stat_t STAT_OUTSIDE = 3'd1;
	localparam stat_t STAT_EMPTY   = 3'd2;
	localparam stat_t STAT_FULL    = 3'd3;
	localparam stat_t STAT_NO_DATA = 3'd4;

	localparam logic CFG_ROWS = 1'b0;
	localparam logic CFG_COLS = 1'b1;

endpackage
`default_nettype wire

FILE: design/ghist_div.sv
`default_nettype none
module ghist_div (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              start,
	input  wire ghist_pkg::count_t dividend,
	input  wire ghist_pkg::count_t divisor,
	output logic                   done,
	output ghist_pkg::share_t      quotient
);
	import ghist_pkg::*;

	localparam int STEPS    = SHARE_BITS - 1;
	localparam int CNT_BITS = $clog2(STEPS);
	localparam logic [CNT_BITS-1:0] LAST_STEP = CNT_BITS'(STEPS - 1);

	count_t                      rem_q;
	count_t                      div_q;
	share_t                      quo_q;
	logic [CNT_BITS-1:0]         cnt_q;
	logic                        active_q;
	logic                        done_q;

	logic                        first_ge;
	logic [COUNT_BITS:0]         rem_shift;
	logic                        step_ge;

	// The dividend never exceeds the divisor, so the integer quotient bit is
	// settled when start is taken and only the fraction bits are iterated.
	assign first_ge  = dividend >= divisor;
	assign rem_shift = {rem_q, 1'b0};
	assign step_ge   = rem_shift >= {1'b0, div_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
			done_q   <= 1'b0;
			cnt_q    <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				active_q <= 1'b1;
				cnt_q    <= '0;
			end else if (active_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == LAST_STEP) begin
					active_q <= 1'b0;
					done_q   <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			div_q <= divisor;
			rem_q <= first_ge ? dividend - divisor : dividend;
			quo_q <= {{(SHARE_BITS-1){1'b0}}, first_ge};
		end else if (active_q) begin
			rem_q <= step_ge ? count_t'(rem_shift - {1'b0, div_q}) : rem_shift[COUNT_BITS-1:0];
			quo_q <= {quo_q[SHARE_BITS-2:0], step_ge};
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule
`default_nettype wire

FILE: design/grid_occupancy_histogram.sv
`default_nettype none
// Channel   Direction  Handshake                Payload
// request   in         start, busy              req_type, pos_row, pos_col
// result    out        done (one-cycle strobe)  share, cell_count, sample_total, status
// config    in         cfg_we                   cfg_index, cfg_data
//
// Add, remove, an outside cell and a query with no samples pass from the accept
// cycle through the execute state to a registered done strobe; a query that
// divides waits in the divide state for the bit-serial divider, which produces one quotient bit per cycle.
// A clear request sweeps the 4096-entry count memory one entry a cycle and
// answers with the done strobe when the sweep ends. After reset the same sweep runs
// with busy high. The receiver cannot stall: each word is shown for one cycle.
module grid_occupancy_histogram (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              start,
	output logic                   busy,
	input  wire logic [1:0]        req_type,
	input  wire logic [5:0]        pos_row,
	input  wire logic [5:0]        pos_col,
	input  wire logic              cfg_we,
	input  wire logic              cfg_index,
	input  wire ghist_pkg::dim_t   cfg_data,
	output logic                   done,
	output ghist_pkg::share_t      share,
	output ghist_pkg::count_t      cell_count,
	output ghist_pkg::count_t      sample_total,
	output ghist_pkg::stat_t       status
);
	import ghist_pkg::*;

	localparam logic [1:0] ST_CLEAR = 2'd0;
	localparam logic [1:0] ST_IDLE  = 2'd1;
	localparam logic [1:0] ST_EXEC  = 2'd2;
	localparam logic [1:0] ST_DIV   = 2'd3;

	localparam int DEPTH = MAX_ROWS * MAX_COLS;
	localparam addr_t LAST_ADDR = addr_t'(DEPTH - 1);

	logic [1:0] state_q;
	addr_t      clr_addr_q;
	logic       clr_resp_q;
	dim_t       rows_q;
	dim_t       cols_q;
	logic [1:0] req_q;
	addr_t      idx_q;
	logic       outside_q;
	count_t     rdata_q;
	count_t     total_q;

	logic       done_q;
	share_t     share_q;
	count_t     cell_q;
	stat_t      status_q;

	count_t     mem [DEPTH];

	dim_t       rows_lim;
	dim_t       cols_lim;
	logic       accept;
	logic       outside;
	logic       full;
	logic       mem_we;
	addr_t      mem_waddr;
	count_t     mem_wdata;
	logic       div_start;
	logic       div_done;
	share_t     div_quo;
	count_t     div_num;

	assign rows_lim = (rows_q > ROWS_LIMIT) ? ROWS_LIMIT : rows_q;
	assign cols_lim = (cols_q > COLS_LIMIT) ? COLS_LIMIT : cols_q;
	assign outside  = ({1'b0, pos_row} >= rows_lim) || ({1'b0, pos_col} >= cols_lim);
	assign accept   = start && (state_q == ST_IDLE);
	assign full     = (rdata_q == COUNT_MAX) || (total_q == COUNT_MAX);

	assign mem_we = (state_q == ST_CLEAR) ||
		((state_q == ST_EXEC) && !outside_q &&
		 (((req_q == REQ_ADD) && !full) || ((req_q == REQ_REM) && (rdata_q != '0))));
	assign mem_waddr = (state_q == ST_CLEAR) ? clr_addr_q : idx_q;
	assign mem_wdata = (state_q == ST_CLEAR) ? '0 :
		(req_q == REQ_ADD) ? rdata_q + 1'b1 : rdata_q - 1'b1;

	assign div_start = (state_q == ST_EXEC) && (req_q == REQ_QUERY) && !outside_q &&
		(total_q != '0);
	assign div_num   = (rdata_q > total_q) ? total_q : rdata_q;

	ghist_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_num),
		.divisor  (total_q),
		.done     (div_done),
		.quotient (div_quo)
	);

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_waddr] <= mem_wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			rdata_q <= mem[{pos_row, pos_col}];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rows_q <= ROWS_LIMIT;
			cols_q <= COLS_LIMIT;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_ROWS: rows_q <= cfg_data;
				CFG_COLS: cols_q <= cfg_data;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			req_q     <= req_type;
			idx_q     <= {pos_row, pos_col};
			outside_q <= outside;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_CLEAR;
			clr_addr_q <= '0;
			clr_resp_q <= 1'b0;
			total_q    <= '0;
			done_q     <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				ST_CLEAR: begin
					clr_addr_q <= clr_addr_q + 1'b1;
					if (clr_addr_q == LAST_ADDR) begin
						state_q <= ST_IDLE;
						done_q  <= clr_resp_q;
					end
				end
				ST_IDLE: begin
					if (accept) begin
						state_q <= ST_EXEC;
					end
				end
				ST_EXEC: begin
					priority if (req_q == REQ_CLEAR) begin
						state_q    <= ST_CLEAR;
						clr_addr_q <= '0;
						clr_resp_q <= 1'b1;
						total_q    <= '0;
					end else if (div_start) begin
						state_q <= ST_DIV;
					end else begin
						state_q <= ST_IDLE;
						done_q  <= 1'b1;
						if (!outside_q) begin
							if ((req_q == REQ_ADD) && !full) begin
								total_q <= total_q + 1'b1;
							end else if ((req_q == REQ_REM) && (rdata_q != '0) &&
								(total_q != '0)) begin
								total_q <= total_q - 1'b1;
							end
						end
					end
				end
				ST_DIV: begin
					if (div_done) begin
						state_q <= ST_IDLE;
						done_q  <= 1'b1;
					end
				end
			endcase
		end
	end

	// Result payload; only meaningful in the cycle that done is high.
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_CLEAR: begin
				share_q  <= '0;
				cell_q   <= '0;
				status_q <= STAT_OK;
			end
			ST_EXEC: begin
				share_q <= '0;
				priority if (outside_q) begin
					cell_q   <= '0;
					status_q <= STAT_OUTSIDE;
				end else if (req_q == REQ_ADD) begin
					cell_q   <= full ? rdata_q : rdata_q + 1'b1;
					status_q <= full ? STAT_FULL : STAT_OK;
				end else if (req_q == REQ_REM) begin
					cell_q   <= (rdata_q == '0) ? rdata_q : rdata_q - 1'b1;
					status_q <= (rdata_q == '0) ? STAT_EMPTY : STAT_OK;
				end else begin
					cell_q   <= rdata_q;
					status_q <= (total_q == '0) ? STAT_NO_DATA : STAT_OK;
				end
			end
			ST_DIV: begin
				share_q  <= div_quo;
				cell_q   <= rdata_q;
				status_q <= STAT_OK;
			end
			ST_IDLE: begin
				share_q  <= share_q;
				cell_q   <= cell_q;
				status_q <= status_q;
			end
		endcase
	end

	assign busy         = (state_q != ST_IDLE);
	assign done         = done_q;
	assign share        = share_q;
	assign cell_count   = cell_q;
	assign sample_total = total_q;
	assign status       = status_q;

endmodule
`default_nettype wire

FILE: design/ghist_chk.sv
`default_nettype none
module ghist_chk (
	input wire logic              clk,
	input wire logic              arst_n,
	input wire logic              start,
	input wire logic              busy,
	input wire logic              done,
	input wire ghist_pkg::share_t share,
	input wire ghist_pkg::count_t cell_count,
	input wire ghist_pkg::stat_t  status
);
	import ghist_pkg::*;

	// An accepted request always keeps the block busy in the next cycle.
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("block took a request but did not go busy");

	// Two results never come in back-to-back cycles.
	a_done_gap: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("result strobe high in two consecutive cycles");

	a_status_range: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (status == STAT_OK || status == STAT_OUTSIDE || status == STAT_EMPTY ||
			status == STAT_FULL || status == STAT_NO_DATA))
		else $error("result with undefined status code");

	a_outside_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && (status == STAT_OUTSIDE) |-> (share == '0) && (cell_count == '0))
		else $error("outside-grid result carries nonzero data");

	a_error_share: assert property (@(posedge clk) disable iff (!arst_n)
		done && (status != STAT_OK) |-> (share == '0))
		else $error("failed request reports a nonzero share");

endmodule

bind grid_occupancy_histogram ghist_chk u_ghist_chk (
	.clk        (clk),
	.arst_n     (arst_n),
	.start      (start),
	.busy       (busy),
	.done       (done),
	.share      (share),
	.cell_count (cell_count),
	.status     (status)
);
`default_nettype wire

FILE: test/tb.sv
typedef struct packed {
	ghist_pkg::share_t share;
	ghist_pkg::count_t cell_cnt;
	ghist_pkg::count_t total;
	ghist_pkg::stat_t  status;
} hist_answer_t;

// Mirrors the cell counts, the total and the grid size, and keeps the answers
// that the block still owes, oldest first.
class occupancy_tracker;
	ghist_pkg::count_t cells [0:ghist_pkg::MAX_ROWS*ghist_pkg::MAX_COLS-1];
	ghist_pkg::count_t total;
	ghist_pkg::dim_t   rows;
	ghist_pkg::dim_t   cols;
	hist_answer_t      answers_due [$];
	int                mismatches;

	function new();
		clear_all();
		rows = ghist_pkg::ROWS_LIMIT;
		cols = ghist_pkg::COLS_LIMIT;
		mismatches = 0;
	endfunction

	function void clear_all();
		foreach (cells[i])
			cells[i] = '0;
		total = '0;
	endfunction

	function void note_config(logic index, ghist_pkg::dim_t value);
		if (index == ghist_pkg::CFG_ROWS)
			rows = value;
		else
			cols = value;
	endfunction

	function void note_request(logic [1:0] kind, logic [5:0] row, logic [5:0] col);
		hist_answer_t      a;
		int                span_r;
		int                span_c;
		int                idx;
		logic [31:0]       scaled;
		ghist_pkg::count_t c;
		a = '0;
		if (kind == ghist_pkg::REQ_CLEAR) begin
			clear_all();
		end else begin
			span_r = (rows > ghist_pkg::ROWS_LIMIT) ? ghist_pkg::MAX_ROWS : int'(rows);
			span_c = (cols > ghist_pkg::COLS_LIMIT) ? ghist_pkg::MAX_COLS : int'(cols);
			if (int'(row) >= span_r || int'(col) >= span_c) begin
				a.status = ghist_pkg::STAT_OUTSIDE;
			end else begin
				idx = int'(row) * ghist_pkg::MAX_COLS + int'(col);
				case (kind)
					ghist_pkg::REQ_ADD: begin
						if (cells[idx] == ghist_pkg::COUNT_MAX || total == ghist_pkg::COUNT_MAX) begin
							a.status = ghist_pkg::STAT_FULL;
						end else begin
							cells[idx] = cells[idx] + 1'b1;
							total = total + 1'b1;
						end
					end
					ghist_pkg::REQ_REM: begin
						if (cells[idx] == '0) begin
							a.status = ghist_pkg::STAT_EMPTY;
						end else begin
							cells[idx] = cells[idx] - 1'b1;
							if (total != '0)
								total = total - 1'b1;
						end
					end
					default: begin
						if (total == '0) begin
							a.status = ghist_pkg::STAT_NO_DATA;
						end else begin
							c = (cells[idx] > total) ? total : cells[idx];
							scaled = {c, 16'h0000};
							a.share = ghist_pkg::share_t'(scaled / 32'(total));
						end
					end
				endcase
				a.cell_cnt = cells[idx];
			end
		end
		a.total = total;
		answers_due.insert(answers_due.size(), a);
	endfunction

	task report_mismatch(string what, int unsigned got, int unsigned want);
		mismatches++;
		if (mismatches <= 40)
			$display("mismatch: %s got %0d expected %0d", what, got, want);
	endtask

	task check_word(ghist_pkg::share_t sh, ghist_pkg::count_t cnt, ghist_pkg::count_t tot,
			ghist_pkg::stat_t st);
		hist_answer_t a;
		if (answers_due.size() == 0) begin
			report_mismatch("word with no request pending, status", st, 0);
			return;
		end
		a = answers_due.pop_front();
		if (sh !== a.share)
			report_mismatch("share", sh, a.share);
		if (cnt !== a.cell_cnt)
			report_mismatch("cell_count", cnt, a.cell_cnt);
		if (tot !== a.total)
			report_mismatch("sample_total", tot, a.total);
		if (st !== a.status)
			report_mismatch("status", st, a.status);
	endtask
endclass

module tb;
	import ghist_pkg::*;

	// Most of a correct run is spent in the clear sweeps.
	localparam int unsigned CYCLE_LIMIT = 3_000_000;

	logic        clk;
	logic        arst_n;
	logic        start;
	logic        busy;
	logic [1:0]  req_type;
	logic [5:0]  pos_row;
	logic [5:0]  pos_col;
	logic        cfg_we;
	logic        cfg_index;
	dim_t        cfg_data;
	logic        done;
	share_t      share;
	count_t      cell_count;
	count_t      sample_total;
	stat_t       status;

	occupancy_tracker tracker = new();
	int unsigned      cycles = 0;

	grid_occupancy_histogram u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.req_type     (req_type),
		.pos_row      (pos_row),
		.pos_col      (pos_col),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.done         (done),
		.share        (share),
		.cell_count   (cell_count),
		.sample_total (sample_total),
		.status       (status)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (done)
				tracker.check_word(share, cell_count, sample_total, status);
			if (start && !busy)
				tracker.note_request(req_type, pos_row, pos_col);
			if (cfg_we)
				tracker.note_config(cfg_index, cfg_data);
		end
	end

	// Returns at the edge that accepted the word. With no gap, start stays high
	// so the next word follows back to back.
	task automatic issue(input logic [1:0] kind, input logic [5:0] row, input logic [5:0] col,
			input int gap);
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start <= 1'b1;
		req_type <= kind;
		pos_row <= row;
		pos_col <= col;
		@(posedge clk);
		while (busy)
			@(posedge clk);
	endtask

	task automatic settle();
		start <= 1'b0;
		@(posedge clk);
		while (tracker.answers_due.size() != 0 || busy)
			@(posedge clk);
		repeat (24) @(posedge clk);
	endtask

	task automatic set_grid(input dim_t r, input dim_t c);
		cfg_we <= 1'b1;
		cfg_index <= CFG_ROWS;
		cfg_data <= r;
		@(posedge clk);
		cfg_index <= CFG_COLS;
		cfg_data <= c;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic random_phase(input dim_t r, input dim_t c, input int n);
		int         span_r;
		int         span_c;
		int         pick;
		int         row;
		int         col;
		int         gap;
		int         i;
		logic [1:0] kind;
		span_r = (r > ROWS_LIMIT) ? MAX_ROWS : int'(r);
		span_c = (c > COLS_LIMIT) ? MAX_COLS : int'(c);
		settle();
		set_grid(r, c);
		for (i = 0; i < n; i++) begin
			pick = $urandom_range(0, 99);
			kind = (pick == 0) ? REQ_CLEAR : (pick < 42) ? REQ_ADD :
				(pick < 67) ? REQ_REM : REQ_QUERY;
			// Half of the requests land in a few hot cells so removes and queries
			// see real counts; some roam the grid and some fall anywhere.
			pick = $urandom_range(0, 9);
			if (span_r == 0 || span_c == 0 || pick < 2) begin
				row = $urandom_range(0, 63);
				col = $urandom_range(0, 63);
			end else if (pick < 7) begin
				row = $urandom_range(0, ((span_r < 4) ? span_r : 4) - 1);
				col = $urandom_range(0, ((span_c < 4) ? span_c : 4) - 1);
			end else begin
				row = $urandom_range(0, span_r - 1);
				col = $urandom_range(0, span_c - 1);
			end
			gap = (i % 80 < 20) ? 0 : $urandom_range(0, 16);
			issue(kind, row[5:0], col[5:0], gap);
		end
	endtask

	initial begin
		arst_n = 1'b0;
		start = 1'b0;
		req_type = REQ_ADD;
		pos_row = '0;
		pos_col = '0;
		cfg_we = 1'b0;
		cfg_index = CFG_ROWS;
		cfg_data = '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		settle();

		// Directed words, starting from the grid size left by reset.
		issue(REQ_QUERY, 6'd0, 6'd0, 0);
		issue(REQ_REM, 6'd0, 6'd0, 3);
		issue(REQ_ADD, 6'd0, 6'd0, 0);
		issue(REQ_ADD, 6'd63, 6'd63, 5);
		issue(REQ_ADD, 6'd63, 6'd63, 0);
		issue(REQ_QUERY, 6'd63, 6'd63, 0);
		issue(REQ_QUERY, 6'd0, 6'd0, 16);
		issue(REQ_QUERY, 6'd21, 6'd42, 0);
		issue(REQ_REM, 6'd63, 6'd63, 1);
		issue(REQ_ADD, 6'd42, 6'd21, 0);
		issue(REQ_CLEAR, 6'd63, 6'd63, 2);
		issue(REQ_QUERY, 6'd63, 6'd63, 0);
		issue(REQ_ADD, 6'd63, 6'd63, 0);
		settle();
		set_grid(7'd0, 7'd64);
		issue(REQ_ADD, 6'd0, 6'd0, 0);
		issue(REQ_QUERY, 6'd0, 6'd0, 0);
		settle();
		// A one-cell grid hides the far corner, whose sample still counts.
		set_grid(7'd1, 7'd1);
		issue(REQ_ADD, 6'd0, 6'd0, 0);
		issue(REQ_ADD, 6'd0, 6'd1, 0);
		issue(REQ_REM, 6'd1, 6'd0, 4);
		issue(REQ_QUERY, 6'd0, 6'd0, 0);
		issue(REQ_QUERY, 6'd63, 6'd63, 0);
		settle();
		set_grid(7'd127, 7'd65);
		issue(REQ_QUERY, 6'd63, 6'd63, 0);
		issue(REQ_REM, 6'd63, 6'd63, 0);
		issue(REQ_QUERY, 6'd0, 6'd0, 0);
		issue(REQ_CLEAR, 6'd0, 6'd63, 0);

		random_phase(7'd64, 7'd64, 300);
		random_phase(7'd1, 7'd1, 200);
		random_phase(7'd0, 7'd7, 60);
		random_phase(7'd127, 7'd65, 250);
		random_phase(7'd5, 7'd3, 200);
		random_phase(7'd64, 7'd1, 200);
		random_phase(7'd1, 7'd64, 200);
		random_phase(dim_t'($urandom_range(1, 127)), dim_t'($urandom_range(1, 127)), 250);
		random_phase(dim_t'($urandom_range(1, 127)), dim_t'($urandom_range(1, 127)), 250);

		settle();

		if (tracker.mismatches == 0 && tracker.answers_due.size() == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end
endmodule

FILE: filelist.f
design/ghist_pkg.sv
design/ghist_div.sv
design/grid_occupancy_histogram.sv
design/ghist_chk.sv
test/tb.sv
